>>> rtl/core/gamf_pkg.sv
// ----------------------------------------------------------------------------
// gamf_pkg: shared types and constants of the alignment matrix fill unit
// Sizes of the line store, register map codes, traceback codes and the
// context record that moves from the sequencer to the cell stage.
// ----------------------------------------------------------------------------
package gamf_pkg;

    // Matrix limits and field widths
    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLUMNS = 1024;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int POS_W       = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int CNT_W       = 11;
    localparam int GAP_W       = 16;
    localparam int MATCH_W     = 16;
    localparam int SCORE_W     = 32;
    localparam int PROD_W      = POS_W + 1 + GAP_W;
    localparam int LINE_W      = SCORE_W + MATCH_W;

    // Configuration port
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_GAP_PENALTY  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'hFFFF;
    localparam logic [CNT_W-1:0] ROW_COUNT_RESET    = CNT_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0] COLUMN_COUNT_RESET = CNT_W'(MAX_COLUMNS);

    // Traceback direction
    typedef enum logic [1:0] {
        DIR_DIAG = 2'd0,
        DIR_UP   = 2'd1,
        DIR_LEFT = 2'd2
    } dir_t;

    // Cell context handed from the sequencer to the cell stage
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [MATCH_W-1:0] match;
        logic [SCORE_W-1:0] border_score;
        logic               border;
        dir_t               border_dir;
        logic               last;
    } cell_ctx_t;

endpackage

>>> rtl/core/gamf_line_store.sv
// ----------------------------------------------------------------------------
// gamf_line_store: previous-column line store
// One entry per row holding the score and match value of the previous
// column. One write and one read port, registered read data, with a bypass
// when the read and the write hit the same row at the same edge.
// ----------------------------------------------------------------------------
module gamf_line_store (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [gamf_pkg::ROW_W-1:0]  rd_addr,
    input  logic                        wr_en,
    input  logic [gamf_pkg::ROW_W-1:0]  wr_addr,
    input  logic [gamf_pkg::LINE_W-1:0] wr_data,
    output logic [gamf_pkg::LINE_W-1:0] rd_data
);
    import gamf_pkg::*;

    logic [LINE_W-1:0] mem [MAX_ROWS];
    logic [LINE_W-1:0] rd_q_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, capture the bypass on a same-row collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

endmodule

>>> rtl/core/gamf_seq.sv
// ----------------------------------------------------------------------------
// gamf_seq: cell position sequencer
// Walks the matrix in column-major order, flags the final cell and forms
// the border score of column 0 and row 0 cells.
// ----------------------------------------------------------------------------
module gamf_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic signed [gamf_pkg::GAP_W-1:0] gap_penalty,
    input  logic [gamf_pkg::CNT_W-1:0]        row_count,
    input  logic [gamf_pkg::CNT_W-1:0]        column_count,
    input  logic [gamf_pkg::MATCH_W-1:0]      match_score,
    output logic [gamf_pkg::ROW_W-1:0]        rd_addr,
    output gamf_pkg::cell_ctx_t               ctx
);
    import gamf_pkg::*;

    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [CNT_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;
    logic             row_wrap;
    logic             col_wrap;
    logic [POS_W-1:0] border_pos;
    logic signed [PROD_W-1:0] border_prod;

    // Clamp the counts into the supported range
    always_comb
    begin
        if (row_count == '0)
            rows_eff = CNT_W'(1);
        else if (row_count > CNT_W'(MAX_ROWS))
            rows_eff = CNT_W'(MAX_ROWS);
        else
            rows_eff = row_count;

        if (column_count == '0)
            cols_eff = CNT_W'(1);
        else if (column_count > CNT_W'(MAX_COLUMNS))
            cols_eff = CNT_W'(MAX_COLUMNS);
        else
            cols_eff = column_count;
    end

    assign row_wrap = (CNT_W'(row_pos_reg) + CNT_W'(1)) >= rows_eff;
    assign col_wrap = (CNT_W'(col_pos_reg) + CNT_W'(1)) >= cols_eff;

    // Advance the position after each transfer
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (accept)
        begin
            if (row_wrap)
            begin
                row_pos_next = '0;
                col_pos_next = col_wrap ? '0 : col_pos_reg + COL_W'(1);
            end
            else
            begin
                row_pos_next = row_pos_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // Border score: row*gap in column 0, column*gap in row 0
    assign border_pos  = (col_pos_reg == '0) ? POS_W'(row_pos_reg) : POS_W'(col_pos_reg);
    assign border_prod = $signed({1'b0, border_pos}) * gap_penalty;

    // Build the cell context
    always_comb
    begin
        ctx.row          = row_pos_reg;
        ctx.col          = col_pos_reg;
        ctx.match        = match_score;
        ctx.border_score = {{(SCORE_W-PROD_W){border_prod[PROD_W-1]}}, border_prod};
        ctx.border       = (row_pos_reg == '0) || (col_pos_reg == '0);
        ctx.last         = row_wrap && col_wrap;
        if (col_pos_reg == '0)
            ctx.border_dir = (row_pos_reg == '0) ? DIR_DIAG : DIR_UP;
        else
            ctx.border_dir = DIR_LEFT;
    end

    assign rd_addr = row_pos_reg;

endmodule

>>> rtl/core/gamf_cell_pe.sv
// ----------------------------------------------------------------------------
// gamf_cell_pe: cell scoring stage and result register
// Combines the cell above, the line store entry and the diagonal term,
// writes the new score back to the line store and holds the result until
// the receiver takes it.
// ----------------------------------------------------------------------------
module gamf_cell_pe (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  gamf_pkg::cell_ctx_t               ctx_in,
    input  logic signed [gamf_pkg::GAP_W-1:0] gap_penalty,
    input  logic [gamf_pkg::LINE_W-1:0]       rd_data,
    output logic                              ready,
    output logic                              wr_en,
    output logic [gamf_pkg::ROW_W-1:0]        wr_addr,
    output logic [gamf_pkg::LINE_W-1:0]       wr_data,
    input  logic                              cell_stall,
    output logic                              cell_valid,
    output logic signed [gamf_pkg::SCORE_W-1:0] cell_score,
    output logic [1:0]                        direction,
    output logic [gamf_pkg::ROW_W-1:0]        row_index,
    output logic [gamf_pkg::COL_W-1:0]        column_index,
    output logic                              last_cell
);
    import gamf_pkg::*;

    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0] sum;
        logic signed [SCORE_W-1:0] res;
        sum = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (sum[SCORE_W] != sum[SCORE_W-1])
            res = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
        else
            res = sum[SCORE_W-1:0];
        return res;
    endfunction

    logic                       s1_valid_reg;
    cell_ctx_t                  ctx_reg;
    logic signed [SCORE_W-1:0]  running_best_reg;
    logic signed [SCORE_W-1:0]  diag_reg;
    logic                       out_valid_reg;
    logic signed [SCORE_W-1:0]  out_score_reg;
    dir_t                       out_dir_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [COL_W-1:0]           out_col_reg;
    logic                       out_last_reg;

    logic                       s1_go;
    logic signed [SCORE_W-1:0]  gap_ext;
    logic signed [SCORE_W-1:0]  old_total;
    logic signed [SCORE_W-1:0]  old_match_ext;
    logic signed [SCORE_W-1:0]  up_score;
    logic signed [SCORE_W-1:0]  left_score;
    logic signed [SCORE_W-1:0]  best_score;
    logic signed [SCORE_W-1:0]  score;
    dir_t                       pick;
    dir_t                       dir_out;

    // Advance the cell stage when the result register is free or emptying
    assign s1_go = s1_valid_reg && (!out_valid_reg || !cell_stall);
    assign ready = !s1_valid_reg || s1_go;

    assign gap_ext       = {{(SCORE_W-GAP_W){gap_penalty[GAP_W-1]}}, gap_penalty};
    assign old_total     = rd_data[LINE_W-1:MATCH_W];
    assign old_match_ext = {{(SCORE_W-MATCH_W){rd_data[MATCH_W-1]}}, rd_data[MATCH_W-1:0]};

    // Pick the best of up, left and diagonal
    always_comb
    begin
        up_score   = sat_add(running_best_reg, gap_ext);
        left_score = sat_add(old_total, gap_ext);
        if (up_score > left_score)
        begin
            best_score = up_score;
            pick       = DIR_UP;
        end
        else
        begin
            best_score = left_score;
            pick       = DIR_LEFT;
        end
        if (diag_reg >= best_score)
        begin
            best_score = diag_reg;
            pick       = DIR_DIAG;
        end

        if (ctx_reg.border)
        begin
            score   = $signed(ctx_reg.border_score);
            dir_out = ctx_reg.border_dir;
        end
        else
        begin
            score   = best_score;
            dir_out = pick;
        end
    end

    // Write the new score and match back to the line store
    assign wr_en   = s1_go;
    assign wr_addr = ctx_reg.row;
    assign wr_data = {score, ctx_reg.match};

    // Control and carried state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            running_best_reg <= '0;
            diag_reg         <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go)
            begin
                out_valid_reg    <= 1'b1;
                running_best_reg <= score;
                diag_reg         <= sat_add(old_total, old_match_ext);
            end
            else if (!cell_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            ctx_reg <= ctx_in;
        if (s1_go)
        begin
            out_score_reg <= score;
            out_dir_reg   <= dir_out;
            out_row_reg   <= ctx_reg.row;
            out_col_reg   <= ctx_reg.col;
            out_last_reg  <= ctx_reg.last;
        end
    end

    assign cell_valid   = out_valid_reg;
    assign cell_score   = out_score_reg;
    assign direction    = out_dir_reg;
    assign row_index    = out_row_reg;
    assign column_index = out_col_reg;
    assign last_cell    = out_last_reg;

endmodule

>>> rtl/core/global_alignment_matrix_fill_unit.sv
// ----------------------------------------------------------------------------
// global_alignment_matrix_fill_unit: global alignment score matrix fill
// Fills a Needleman-Wunsch score matrix with a linear gap cost, one cell
// per match score, and reports each cell's score and traceback direction.
// ----------------------------------------------------------------------------
// Usage:
//   Match scores enter on the match channel in column-major order (row
//   index runs fastest). Each transfer yields one result on the cell
//   channel: saturated score, traceback direction, row, column and a flag
//   on the final cell of the matrix.
//   The input transfer loads the scoring stage register; the result register
//   loads from it when it is empty or the cell channel is not stalled.
//   Throughput: one cell per cycle unless stalled. The line store keeps the
//   previous column in a single memory with one read and one write per cycle;
//   the read is issued at the input transfer and the write-back at the scoring
//   stage, with a bypass when both hit the same row.
//   Stall: while the cell channel is stalled the result register holds, the
//   scoring stage still accepts one more cell, and then the match channel
//   stalls.
//   Reset: the position returns to the origin, the carried scores clear and
//   the registers take gap -1 and 1024 rows by 1024 columns. The line store
//   needs no clearing pass; every entry is written before it is read. Users
//   write registers over the APB port only while the unit is idle; unenforced.
// ----------------------------------------------------------------------------
module global_alignment_matrix_fill_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gamf_pkg::ADDR_W-1:0]         paddr,
    input  logic [gamf_pkg::DATA_W-1:0]         pwdata,
    output logic [gamf_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    // Match score channel
    input  logic                                match_valid,
    output logic                                match_stall,
    input  logic signed [gamf_pkg::MATCH_W-1:0] match_score,
    // Cell result channel
    output logic                                cell_valid,
    input  logic                                cell_stall,
    output logic signed [gamf_pkg::SCORE_W-1:0] cell_score,
    output logic [1:0]                          direction,
    output logic [gamf_pkg::ROW_W-1:0]          row_index,
    output logic [gamf_pkg::COL_W-1:0]          column_index,
    output logic                                last_cell
);
    import gamf_pkg::*;

    logic [GAP_W-1:0]     gap_penalty_reg;
    logic [CNT_W-1:0]     row_count_reg;
    logic [CNT_W-1:0]     column_count_reg;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    logic                 accept;
    logic                 pe_ready;
    cell_ctx_t            ctx;
    logic [ROW_W-1:0]     rd_addr;
    logic [LINE_W-1:0]    rd_data;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [LINE_W-1:0]    wr_data;

    // Register file
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_penalty_reg  <= GAP_RESET;
            row_count_reg    <= ROW_COUNT_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_GAP_PENALTY:  gap_penalty_reg  <= pwdata[GAP_W-1:0];
                REG_ROW_COUNT:    row_count_reg    <= pwdata[CNT_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GAP_PENALTY:
                prdata = {{(DATA_W-GAP_W){gap_penalty_reg[GAP_W-1]}}, gap_penalty_reg};
            REG_ROW_COUNT:
                prdata = {{(DATA_W-CNT_W){1'b0}}, row_count_reg};
            REG_COLUMN_COUNT:
                prdata = {{(DATA_W-CNT_W){1'b0}}, column_count_reg};
            default:
                prdata = '0;
        endcase
    end

    // Input transfer
    assign match_stall = !pe_ready;
    assign accept      = match_valid && pe_ready;

    gamf_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .gap_penalty  ($signed(gap_penalty_reg)),
        .row_count    (row_count_reg),
        .column_count (column_count_reg),
        .match_score  (match_score),
        .rd_addr      (rd_addr),
        .ctx          (ctx)
    );

    gamf_line_store u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    gamf_cell_pe u_cell_pe (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .ctx_in       (ctx),
        .gap_penalty  ($signed(gap_penalty_reg)),
        .rd_data      (rd_data),
        .ready        (pe_ready),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .cell_stall   (cell_stall),
        .cell_valid   (cell_valid),
        .cell_score   (cell_score),
        .direction    (direction),
        .row_index    (row_index),
        .column_index (column_index),
        .last_cell    (last_cell)
    );

endmodule

>>> rtl/core/gamf_checker.sv
// ----------------------------------------------------------------------------
// gamf_port_checker: port-level checks of the alignment matrix fill unit
// Watches the result channel for held transfers and border cell rules.
// ----------------------------------------------------------------------------
module gamf_port_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cell_valid,
    input  logic                                cell_stall,
    input  logic signed [gamf_pkg::SCORE_W-1:0] cell_score,
    input  logic [1:0]                          direction,
    input  logic [gamf_pkg::ROW_W-1:0]          row_index,
    input  logic [gamf_pkg::COL_W-1:0]          column_index
);
    import gamf_pkg::*;

    // Hold a stalled result
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_stall |=> cell_valid && $stable(cell_score)
            && $stable(direction) && $stable(row_index) && $stable(column_index))
        else $error("stalled cell result changed");

    // Traceback code stays within diagonal, up and left
    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid |-> (direction == DIR_DIAG) || (direction == DIR_UP)
            || (direction == DIR_LEFT))
        else $error("unused traceback code");

    // Origin scores zero with a diagonal direction
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && (row_index == '0) && (column_index == '0)
            |-> (cell_score == '0) && (direction == DIR_DIAG))
        else $error("origin cell wrong");

    // Column 0 cells below the origin point up, row 0 cells point left
    a_border_dir: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && (column_index == '0) && (row_index != '0)
            |-> direction == DIR_UP)
        else $error("column 0 cell not up");

    a_top_row_dir: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && (row_index == '0) && (column_index != '0)
            |-> direction == DIR_LEFT)
        else $error("row 0 cell not left");

endmodule

bind global_alignment_matrix_fill_unit gamf_port_checker u_gamf_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_score   (cell_score),
    .direction    (direction),
    .row_index    (row_index),
    .column_index (column_index)
);

>>> sim/gamf_checker.sv
// ----------------------------------------------------------------------------
// gamf_checker: scoreboard of the alignment matrix fill unit
// Watches the APB port, the match channel and the cell channel. It keeps its
// own copy of the register settings, the line store and the carried scores.
// From each match transfer it works out the expected cell. It then compares
// each cell transfer, field by field, with the oldest expected cell.
// ----------------------------------------------------------------------------
module gamf_checker
    import gamf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    input  logic                       pready,
    input  logic                       match_valid,
    input  logic                       match_stall,
    input  logic signed [MATCH_W-1:0]  match_score,
    input  logic                       cell_valid,
    input  logic                       cell_stall,
    input  logic signed [SCORE_W-1:0]  cell_score,
    input  logic [1:0]                 direction,
    input  logic [ROW_W-1:0]           row_index,
    input  logic [COL_W-1:0]           column_index,
    input  logic                       last_cell,
    output int                         pending_cells,
    output int                         fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SCORE_MAX = (longint'(1) <<< (SCORE_W - 1)) - 1;
    localparam longint SCORE_MIN = -(longint'(1) <<< (SCORE_W - 1));

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        dir_t                      dir;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic                      last;
    } cell_result_t;

    cell_result_t              expected_cells[$];
    cell_result_t              want;

    // Shadow of the unit's line store and carried scores
    logic signed [SCORE_W-1:0] column_scores [MAX_ROWS];
    logic signed [MATCH_W-1:0] column_matches [MAX_ROWS];
    logic signed [SCORE_W-1:0] above_score;
    logic signed [SCORE_W-1:0] diag_score;
    logic signed [MATCH_W-1:0] diag_match;
    int unsigned               row_pos;
    int unsigned               col_pos;

    // Shadow of the registers
    logic signed [GAP_W-1:0]   gap;
    logic [CNT_W-1:0]          row_cnt;
    logic [CNT_W-1:0]          col_cnt;

    initial
    begin
        fail_count    = 0;
        pending_cells = 0;
    end

    function automatic logic signed [SCORE_W-1:0] saturate(input longint v);
        if (v > SCORE_MAX)
            return SCORE_MAX[SCORE_W-1:0];
        if (v < SCORE_MIN)
            return SCORE_MIN[SCORE_W-1:0];
        return v[SCORE_W-1:0];
    endfunction

    // Zero acts as one, anything above the limit acts as the limit
    function automatic int unsigned effective_count(input logic [CNT_W-1:0] v,
                                                    input int unsigned limit);
        if (v == '0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Score the cell at the current position and advance the position
    task automatic score_cell(input logic signed [MATCH_W-1:0] m);
        int unsigned               rows;
        int unsigned               cols;
        logic signed [SCORE_W-1:0] up;
        logic signed [SCORE_W-1:0] left;
        logic signed [SCORE_W-1:0] diag;
        logic signed [SCORE_W-1:0] best;
        logic signed [SCORE_W-1:0] old_total;
        logic signed [MATCH_W-1:0] old_match;
        dir_t                      pick;
        cell_result_t              res;

        rows      = effective_count(row_cnt, MAX_ROWS);
        cols      = effective_count(col_cnt, MAX_COLUMNS);
        old_total = column_scores[row_pos];
        old_match = column_matches[row_pos];

        if (row_pos == 0 && col_pos == 0)
        begin
            best = '0;
            pick = DIR_DIAG;
        end
        else if (col_pos == 0)
        begin
            best = saturate(longint'(row_pos) * longint'(gap));
            pick = DIR_UP;
        end
        else if (row_pos == 0)
        begin
            best = saturate(longint'(col_pos) * longint'(gap));
            pick = DIR_LEFT;
        end
        else
        begin
            up   = saturate(longint'(above_score) + longint'(gap));
            left = saturate(longint'(old_total) + longint'(gap));
            diag = saturate(longint'(diag_score) + longint'(diag_match));
            // Tie between up and left goes to left, diagonal wins any tie
            if (up > left)
            begin
                best = up;
                pick = DIR_UP;
            end
            else
            begin
                best = left;
                pick = DIR_LEFT;
            end
            if (diag >= best)
            begin
                best = diag;
                pick = DIR_DIAG;
            end
        end

        diag_score              = old_total;
        diag_match              = old_match;
        column_scores[row_pos]  = best;
        column_matches[row_pos] = m;
        above_score             = best;

        res.score = best;
        res.dir   = pick;
        res.row   = row_pos[ROW_W-1:0];
        res.col   = col_pos[COL_W-1:0];
        res.last  = (row_pos + 1 >= rows) && (col_pos + 1 >= cols);
        expected_cells.push_back(res);

        // Wrap the row, then the column
        if (row_pos + 1 >= rows)
        begin
            row_pos = 0;
            col_pos = (col_pos + 1 >= cols) ? 0 : col_pos + 1;
        end
        else
        begin
            row_pos = row_pos + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [SCORE_W-1:0] exp_val,
                               input logic [SCORE_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch at row %0d column %0d: expected %0h, got %0h",
                         $realtime, name, want.row, want.col, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_cells.delete();
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                column_scores[i]  = '0;
                column_matches[i] = '0;
            end
            above_score   = '0;
            diag_score    = '0;
            diag_match    = '0;
            row_pos       = 0;
            col_pos       = 0;
            gap           = GAP_RESET;
            row_cnt       = ROW_COUNT_RESET;
            col_cnt       = COLUMN_COUNT_RESET;
            pending_cells = 0;
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_GAP_PENALTY:  gap     = pwdata[GAP_W-1:0];
                    REG_ROW_COUNT:    row_cnt = pwdata[CNT_W-1:0];
                    REG_COLUMN_COUNT: col_cnt = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (match_valid && !match_stall)
                score_cell(match_score);

            // Compare each cell transfer with the oldest expected cell
            if (cell_valid && !cell_stall)
            begin
                if (expected_cells.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: cell transfer with nothing expected: row %0d column %0d",
                                 $realtime, row_index, column_index);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    check_field("cell_score", want.score, cell_score);
                    check_field("direction", want.dir, direction);
                    check_field("row_index", want.row, row_index);
                    check_field("column_index", want.col, column_index);
                    check_field("last_cell", want.last, last_cell);
                end
            end

            pending_cells = expected_cells.size();
        end
    end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the alignment matrix fill unit
// Programs gap and matrix size over APB and streams match scores with
// bursts and gaps while the cell side stalls on its own pattern. It starts
// with a short directed set: extreme gaps and scores, ties, out-of-range
// counts. Random phases follow, and they change the settings mid-matrix.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gamf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 800;
    localparam int CNT_MAX        = (1 << CNT_W) - 1;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       match_valid;
    logic                       match_stall;
    logic signed [MATCH_W-1:0]  match_score;
    logic                       cell_valid;
    logic                       cell_stall;
    logic signed [SCORE_W-1:0]  cell_score;
    logic [1:0]                 direction;
    logic [ROW_W-1:0]           row_index;
    logic [COL_W-1:0]           column_index;
    logic                       last_cell;
    int                         pending_cells;
    int                         fail_count;

    // Sender state and the position of the next cell
    int                         burst_left;
    bit                         idle_on;
    int unsigned                pos_r;
    int unsigned                pos_c;
    int unsigned                eff_rows;
    int unsigned                eff_cols;
    int                         idle_cycles;

    global_alignment_matrix_fill_unit u_dut (.*);

    gamf_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the cell side in runs of random length
    initial
    begin
        int unsigned run_len;
        bit          stall_level;

        cell_stall  = 1'b0;
        run_len     = 0;
        stall_level = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run_len == 0)
            begin
                stall_level = !stall_level;
                run_len     = stall_level ? $urandom_range(1, 8) : $urandom_range(1, 40);
            end
            run_len--;
            cell_stall <= stall_level;
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((match_valid && !match_stall) || (cell_valid && !cell_stall)
                || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned effective_count(input logic [CNT_W-1:0] v,
                                                    input int unsigned limit);
        if (v == '0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic logic [GAP_W-1:0] pick_gap();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return '0;
            3:       return GAP_W'($urandom);
            default: return GAP_W'(int'($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    function automatic logic [MATCH_W-1:0] pick_match();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return MATCH_W'($urandom);
            default: return MATCH_W'(int'($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_rows();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CNT_W'(MAX_ROWS);
            2:       return CNT_W'($urandom_range(MAX_ROWS + 1, CNT_MAX));
            3, 4, 5: return CNT_W'($urandom_range(9, 48));
            default: return CNT_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_cols();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CNT_W'(MAX_COLUMNS);
            2:       return CNT_W'($urandom_range(MAX_COLUMNS + 1, CNT_MAX));
            3, 4, 5: return CNT_W'($urandom_range(7, 32));
            default: return CNT_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Drop valid and hold until every expected cell has arrived
    task automatic wait_drained();
        @(negedge clk);
        match_valid <= 1'b0;
        while (pending_cells != 0)
            @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value,
                             input int width);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        // Fill the bits above the register with junk now and then
        pwdata  <= value | (($urandom_range(0, 3) == 0) ? ($urandom << width) : '0);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_matrix(input logic [GAP_W-1:0] gap, input logic [CNT_W-1:0] rows,
                                  input logic [CNT_W-1:0] cols);
        wait_drained();
        repeat (2) @(negedge clk);
        write_reg(REG_GAP_PENALTY, DATA_W'(gap), GAP_W);
        write_reg(REG_ROW_COUNT, DATA_W'(rows), CNT_W);
        write_reg(REG_COLUMN_COUNT, DATA_W'(cols), CNT_W);
        eff_rows = effective_count(rows, MAX_ROWS);
        eff_cols = effective_count(cols, MAX_COLUMNS);
    endtask

    // One match transfer, preceded by a random gap at the start of each burst
    task automatic send_match(input logic [MATCH_W-1:0] value);
        int gap_len;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap_len    = idle_on ? $urandom_range(0, 6) : 0;
            if (idle_on && $urandom_range(0, 7) == 0)
                gap_len = $urandom_range(7, 20);
            repeat (gap_len)
            begin
                @(negedge clk);
                match_valid <= 1'b0;
                match_score <= MATCH_W'($urandom);
            end
        end
        @(negedge clk);
        match_valid <= 1'b1;
        match_score <= value;
        do
            @(posedge clk);
        while (match_stall);
        burst_left--;

        // Advance the position the same way the unit does
        if (pos_r + 1 >= eff_rows)
        begin
            pos_r = 0;
            pos_c = (pos_c + 1 >= eff_cols) ? 0 : pos_c + 1;
        end
        else
        begin
            pos_r = pos_r + 1;
        end
    endtask

    initial
    begin
        logic [MATCH_W-1:0] corner_scores [12];
        logic [CNT_W-1:0]   rows;
        int                 sent;
        int                 n;
        int                 pause_at;

        corner_scores = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF,
                          16'h8000, 16'h0005, 16'h8000, 16'h7FFF, 16'hFFFE, 16'h0000};

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        match_valid = 1'b0;
        match_score = '0;
        burst_left  = 0;
        idle_on     = 1'b1;
        pos_r       = 0;
        pos_c       = 0;
        eff_rows    = MAX_ROWS;
        eff_cols    = MAX_COLUMNS;
        sent        = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Most negative gap with extreme match scores
        program_matrix(16'h8000, 11'd4, 11'd3);
        foreach (corner_scores[i])
            send_match(corner_scores[i]);

        // Most positive gap
        program_matrix(16'h7FFF, 11'd3, 11'd2);
        repeat (6) send_match(pick_match());

        // Zero gap and zero scores: every comparison ties
        program_matrix(16'h0000, 11'd2, 11'd2);
        repeat (4) send_match('0);

        // Counts of zero act as one: every cell is the origin and the last cell
        program_matrix(16'hFFFF, 11'd0, 11'd0);
        repeat (2) send_match(pick_match());

        // Counts above the maximum act as the maximum
        program_matrix(16'hFFFD, CNT_W'(CNT_MAX), CNT_W'(CNT_MAX));
        repeat (3) send_match(pick_match());

        // Random phases; a phase may begin mid-matrix
        while (sent < RANDOM_ITEMS)
        begin
            rows = pick_rows();
            // Grow the rows only in column 0 so that no unwritten entry is read
            if (pos_c != 0 && effective_count(rows, MAX_ROWS) > eff_rows)
                rows = CNT_W'(eff_rows);
            program_matrix(pick_gap(), rows, pick_cols());
            idle_on  = ($urandom_range(0, 3) != 0);
            n        = $urandom_range(20, 80);
            pause_at = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++)
            begin
                if (i == pause_at)
                    wait_drained();
                send_match(pick_match());
                sent++;
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
